FILE: sv/tle_pkg.sv
// Package for the terminal line editor: sizes, byte codes, operation codes,
// sequencer states, shared structs and the constant echo text table.
// No dependencies.
package tle_pkg;

  localparam int LineBufLen = 32;
  localparam int AddrW      = $clog2(LineBufLen);
  localparam int LenW       = 6;
  localparam int PtrW       = 6;

  localparam logic [7:0] ChBel  = 8'h07;
  localparam logic [7:0] ChBs   = 8'h08;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChDel  = 8'h7F;
  localparam logic [7:0] ChHiLo = 8'hA0;
  localparam logic [7:0] CtrlR  = 8'h12;
  localparam logic [7:0] CtrlU  = 8'h15;
  localparam logic [7:0] CtrlW  = 8'h17;

  localparam logic [PtrW-1:0] TxtCr       = PtrW'(0);
  localparam logic [PtrW-1:0] TxtLf       = PtrW'(1);
  localparam logic [PtrW-1:0] TxtPromptLo = PtrW'(2);
  localparam logic [PtrW-1:0] TxtPromptHi = PtrW'(8);
  localparam logic [PtrW-1:0] TxtEraseLo  = PtrW'(9);
  localparam logic [PtrW-1:0] TxtEraseHi  = PtrW'(11);
  localparam logic [PtrW-1:0] TxtTagULo   = PtrW'(12);
  localparam logic [PtrW-1:0] TxtTagUHi   = PtrW'(24);
  localparam logic [PtrW-1:0] TxtTagWLo   = PtrW'(25);
  localparam logic [PtrW-1:0] TxtTagWHi   = PtrW'(37);

  typedef enum logic [2:0] {
    OP_NONE, OP_STORE, OP_ERASE, OP_REDRAW, OP_TAG_U, OP_TAG_W, OP_EOL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_ECHO, ST_TEXT, ST_LINE
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       line_last;
    logic       last;
  } tle_res_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic [AddrW-1:0] raddr;
  } tle_ram_req_t;

  function automatic logic [7:0] tag_byte(input logic [3:0] pos, input logic [7:0] letter);
    logic [7:0] b;
    case (pos)
      4'd0:    b = 8'h5B;
      4'd1:    b = 8'h63;
      4'd2:    b = 8'h68;
      4'd3:    b = 8'h72;
      4'd4:    b = 8'h3A;
      4'd5:    b = ChSp;
      4'd6:    b = letter;
      4'd7:    b = 8'h26;
      4'd8:    b = 8'h30;
      4'd9:    b = 8'h78;
      4'd10:   b = 8'h31;
      4'd11:   b = 8'h66;
      4'd12:   b = 8'h5D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] text_byte(input logic [PtrW-1:0] ptr);
    logic [7:0] b;
    case (ptr)
      TxtCr:            b = ChCr;
      TxtLf:            b = ChLf;
      PtrW'(2):         b = ChCr;
      PtrW'(3):         b = ChLf;
      PtrW'(4):         b = 8'h63;
      PtrW'(5):         b = 8'h6D;
      PtrW'(6):         b = 8'h64;
      PtrW'(7):         b = 8'h3A;
      PtrW'(8):         b = ChSp;
      PtrW'(9):         b = ChBs;
      PtrW'(10):        b = ChSp;
      PtrW'(11):        b = ChBs;
      default: begin
        if (ptr >= TxtTagULo && ptr <= TxtTagUHi) begin
          b = tag_byte(4'(ptr - TxtTagULo), 8'h75);
        end else if (ptr >= TxtTagWLo && ptr <= TxtTagWHi) begin
          b = tag_byte(4'(ptr - TxtTagWLo), 8'h77);
        end else begin
          b = 8'h00;
        end
      end
    endcase
    return b;
  endfunction

endpackage

FILE: sv/tle_rx_if.sv
// Receive channel interface: valid/ready handshake carrying one terminal byte.
// No dependencies.
interface tle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: sv/tle_tx_if.sv
// Result channel interface: valid/ready handshake carrying one result item.
// No dependencies.
interface tle_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       kind;
  logic       line_last;
  logic       last;

  modport source (output valid, output out_byte, output kind, output line_last,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input line_last,
                input last, output ready);
endinterface

FILE: sv/tle_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tle_seq.sv
// Sequencer: decodes a received byte, keeps the line length and, while the
// output slot is free, steps one result per cycle from the echo register,
// the text table or the line RAM. Depends on tle_pkg and tle_rx_if.
module tle_seq
  import tle_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  tle_rx_if.sink       rx,
  input  logic         slot_free,
  output logic         push,
  output tle_res_t     res,
  output tle_ram_req_t ram_req,
  input  logic [7:0]   rdata
);

  state_t            state, state_next;
  logic [PtrW-1:0]   ptr, ptr_next;
  logic [PtrW-1:0]   ptr_end, ptr_end_next;
  logic              then_line, then_line_next;
  logic              then_prompt, then_prompt_next;
  logic              line_cmd, line_cmd_next;
  logic [AddrW-1:0]  idx, idx_next;
  logic [LenW-1:0]   len, len_next;
  logic [7:0]        echo_byte, echo_byte_next;

  logic       accept;
  logic [7:0] c;
  op_t        op;
  logic       full;
  logic       idx_last;
  logic       more_line;

  assign accept    = rx.valid && rx.ready;
  assign full      = len >= LenW'(LineBufLen - 1);
  assign idx_last  = (LenW'(idx) + LenW'(1)) == len;
  assign more_line = then_line && (len != '0);

  always_comb begin
    c  = rx.rx_byte;
    op = OP_NONE;
    if (c == ChCr || c == ChLf) begin
      op = OP_EOL;
    end else begin
      if (c == ChTab) begin
        c = ChSp;
      end
      if ((c >= ChSp && c <= ChTilde) || c >= ChHiLo) begin
        op = OP_STORE;
      end else if (c == ChBs || c == ChDel) begin
        op = OP_ERASE;
      end else if (c == CtrlR) begin
        op = OP_REDRAW;
      end else if (c == CtrlU) begin
        op = OP_TAG_U;
      end else if (c == CtrlW) begin
        op = OP_TAG_W;
      end
    end
  end

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    ptr_end_next     = ptr_end;
    then_line_next   = then_line;
    then_prompt_next = then_prompt;
    line_cmd_next    = line_cmd;
    idx_next         = idx;
    len_next         = len;
    echo_byte_next   = echo_byte;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          then_line_next   = 1'b0;
          then_prompt_next = 1'b0;
          case (op)
            OP_STORE: begin
              state_next = ST_ECHO;
              if (full) begin
                echo_byte_next = ChBel;
              end else begin
                echo_byte_next = c;
                len_next       = len + LenW'(1);
              end
            end
            OP_ERASE: begin
              if (len != '0) begin
                len_next     = len - LenW'(1);
                ptr_next     = TxtEraseLo;
                ptr_end_next = TxtEraseHi;
                state_next   = ST_TEXT;
              end
            end
            OP_REDRAW: begin
              ptr_next       = TxtCr;
              ptr_end_next   = TxtCr;
              then_line_next = 1'b1;
              line_cmd_next  = 1'b0;
              state_next     = ST_TEXT;
            end
            OP_TAG_U: begin
              ptr_next     = TxtTagULo;
              ptr_end_next = TxtTagUHi;
              state_next   = ST_TEXT;
            end
            OP_TAG_W: begin
              ptr_next     = TxtTagWLo;
              ptr_end_next = TxtTagWHi;
              state_next   = ST_TEXT;
            end
            OP_EOL: begin
              ptr_next         = TxtCr;
              ptr_end_next     = TxtLf;
              then_line_next   = 1'b1;
              then_prompt_next = 1'b1;
              line_cmd_next    = 1'b1;
              state_next       = ST_TEXT;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_ECHO: begin
        if (push) begin
          state_next = ST_IDLE;
        end
      end
      ST_TEXT: begin
        if (push) begin
          if (ptr == ptr_end) begin
            if (more_line) begin
              idx_next   = '0;
              state_next = ST_LINE;
            end else if (then_prompt) begin
              ptr_next         = TxtPromptLo;
              ptr_end_next     = TxtPromptHi;
              then_prompt_next = 1'b0;
              then_line_next   = 1'b0;
              len_next         = '0;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            ptr_next = ptr + PtrW'(1);
          end
        end
      end
      ST_LINE: begin
        if (push) begin
          if (idx_last) begin
            idx_next = '0;
            if (then_prompt) begin
              ptr_next         = TxtPromptLo;
              ptr_end_next     = TxtPromptHi;
              then_prompt_next = 1'b0;
              then_line_next   = 1'b0;
              len_next         = '0;
              state_next       = ST_TEXT;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            idx_next = idx + AddrW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rx.ready      = (state == ST_IDLE) && !rst;
    push          = (state != ST_IDLE) && slot_free;
    res           = '0;
    ram_req.we    = accept && (op == OP_STORE) && !full;
    ram_req.waddr = len[AddrW-1:0];
    ram_req.wdata = c;
    ram_req.raddr = idx_next;
    case (state)
      ST_ECHO: begin
        res.out_byte = echo_byte;
        res.last     = 1'b1;
      end
      ST_TEXT: begin
        res.out_byte = text_byte(ptr);
        res.last     = (ptr == ptr_end) && !more_line && !then_prompt;
      end
      ST_LINE: begin
        res.out_byte  = rdata;
        res.kind      = line_cmd;
        res.line_last = line_cmd && idx_last;
        res.last      = idx_last && !then_prompt;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      len         <= '0;
      then_line   <= 1'b0;
      then_prompt <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      len         <= len_next;
      then_line   <= then_line_next;
      then_prompt <= then_prompt_next;
    end
    ptr       <= ptr_next;
    ptr_end   <= ptr_end_next;
    line_cmd  <= line_cmd_next;
    echo_byte <= echo_byte_next;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LenW'(LineBufLen - 1))
    else $error("line length past buffer");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LINE) |-> (idx == '0))
    else $error("line index not parked outside line phase");

  a_line_last_kind: assert property (@(posedge clk) disable iff (rst)
    (push && res.line_last) |-> (res.kind && state == ST_LINE))
    else $error("line_last on a terminal byte");

  a_store_grow: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |=> (len == $past(len) + LenW'(1)))
    else $error("stored byte without length step");

  a_line_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINE) |-> (len != '0))
    else $error("line phase on empty line");

endmodule

FILE: sv/terminal_line_editor.sv
// Top level of the terminal line editor: sequencer, line RAM and the output
// register that holds a result item until the sink takes it.
// Depends on tle_pkg, tle_rx_if, tle_tx_if, tle_ram and tle_seq.
//
//   channel  dir  payload                             handshake
//   rx       in   rx_byte[7:0]                        valid/ready
//   tx       out  out_byte[7:0] kind line_last last   valid/ready
//
// An item causes 0 to 40 results (end of a full line: CR LF, 31 line bytes,
// 7 prompt bytes). The sequencer steps one result per cycle, while tx does not
// stall, from the echo register, the text table or the line RAM read port;
// rx.ready is high only while it is idle.
// Reset clears the line length; the line RAM needs no clearing pass.
// A stall on tx holds the sequencer; rx may be taken while a result waits.
module terminal_line_editor
  import tle_pkg::*;
(
  input logic    clk,
  input logic    rst,
  tle_rx_if.sink rx,
  tle_tx_if.source tx
);

  logic         push;
  logic         slot_free;
  tle_res_t     res;
  tle_res_t     out_res;
  tle_ram_req_t ram_req;
  logic [7:0]   rdata;
  logic         out_valid;

  assign slot_free = !out_valid || tx.ready;

  tle_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .slot_free (slot_free),
    .push      (push),
    .res       (res),
    .ram_req   (ram_req),
    .rdata     (rdata)
  );

  tle_ram #(
    .WIDTH (8),
    .DEPTH (LineBufLen)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      out_res <= res;
    end
  end

  assign tx.valid     = out_valid;
  assign tx.out_byte  = out_res.out_byte;
  assign tx.kind      = out_res.kind;
  assign tx.line_last = out_res.line_last;
  assign tx.last      = out_res.last;

endmodule
